[design/icph_pkg.sv]
package icph_pkg;

   // Width of the configuration register index
   localparam int CSR_INDEX_W = 8;

   // Configuration register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_PSEUDO_MODE         = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SOURCE_ADDRESS      = 8'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_DESTINATION_ADDRESS = 8'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_PROTOCOL_NUMBER     = 8'd3;

   // Reset value of the protocol byte (TCP)
   localparam logic [7:0] PROTOCOL_RESET = 8'd6;

   // Keeps the upper byte of a word that carries a lone trailing byte
   localparam logic [15:0] HIGH_BYTE_MASK = 16'hFF00;

   // One classified word on its way from the front to the back
   typedef struct packed {
      logic [15:0] word;
      logic        single;
      logic        last;
   } entry_type;

   // Configuration registers seen by the back end
   typedef struct packed {
      logic        pseudo_mode;
      logic [31:0] source_address;
      logic [31:0] destination_address;
      logic [7:0]  protocol_number;
   } cfg_type;

endpackage

[design/icph_front.sv]
module icph_front (
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [15:0]          req_data_word,
   input  logic                 req_single_byte,
   input  logic                 req_last_item,
   output logic                 push_valid,
   input  logic                 push_ready,
   output icph_pkg::entry_type  push_data
);

   // Accept whenever the queue has room
   assign req_ready  = push_ready;
   assign push_valid = req_valid;

   // Pad a lone trailing byte with a zero low byte, tag the entry
   always_comb begin
      push_data.single = req_single_byte;
      push_data.last   = req_last_item;
      if (req_single_byte) begin
         push_data.word = req_data_word & icph_pkg::HIGH_BYTE_MASK;
      end else begin
         push_data.word = req_data_word;
      end
   end

endmodule

[design/icph_fifo.sv]
module icph_fifo #(
   parameter int DEPTH = 4
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push_valid,
   output logic                 push_ready,
   input  icph_pkg::entry_type  push_data,
   output logic                 pop_valid,
   input  logic                 pop_ready,
   output icph_pkg::entry_type  pop_data
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   icph_pkg::entry_type mem_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic          push_take;
   logic          pop_take;

   assign push_ready = (count_ff != CW'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = mem_ff[rd_ptr_ff];
   assign push_take  = push_valid && push_ready;
   assign pop_take   = pop_valid && pop_ready;

   // Advance pointers with wrap, track fill level
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_take) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (pop_take) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (push_take && !pop_take) begin
         count_in = count_ff + CW'(1);
      end else if (!push_take && pop_take) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store entries, no reset needed for payload
   always_ff @(posedge clock) begin
      if (push_take) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[design/icph_back.sv]
module icph_back (
   input  logic                 clock,
   input  logic                 reset,
   input  icph_pkg::cfg_type    cfg,
   input  logic                 pop_valid,
   output logic                 pop_ready,
   input  icph_pkg::entry_type  pop_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [15:0]          rsp_checksum
);

   // End-around-carry add of two words
   function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
      logic [16:0] s;
      logic [16:0] f;
      s = {1'b0, a} + {1'b0, b};
      f = {1'b0, s[15:0]} + {16'd0, s[16]};
      return f[15:0];
   endfunction

   logic [15:0] sum_ff, sum_in;
   logic [15:0] count_ff, count_in;
   logic [15:0] cfg_sum_ff, cfg_sum_in;
   logic        fin_valid_ff, fin_valid_in;
   logic [15:0] fin_sum_ff;
   logic [15:0] fin_count_ff;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [15:0] rsp_checksum_ff;
   logic [15:0] word_sum;
   logic [15:0] word_count;
   logic [16:0] count_wide;
   logic        take;
   logic        fin_advance;
   logic [18:0] cfg_wide;
   logic [16:0] cfg_fold;
   logic [16:0] cfg_fold2;
   logic [17:0] fin_wide;
   logic [16:0] fin_fold;
   logic [16:0] fin_fold2;
   logic [15:0] final_sum;

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_checksum = rsp_checksum_ff;

   // Pre-sum the address and protocol words of the pseudo-header
   always_comb begin
      cfg_wide = {3'd0, cfg.source_address[31:16]} + {3'd0, cfg.source_address[15:0]}
               + {3'd0, cfg.destination_address[31:16]}
               + {3'd0, cfg.destination_address[15:0]}
               + {11'd0, cfg.protocol_number};
      cfg_fold   = {1'b0, cfg_wide[15:0]} + {14'd0, cfg_wide[18:16]};
      cfg_fold2  = {1'b0, cfg_fold[15:0]} + {16'd0, cfg_fold[16]};
      cfg_sum_in = cfg_fold2[15:0];
   end

   assign fin_advance = fin_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign pop_ready   = !pop_data.last || !fin_valid_ff || fin_advance;
   assign take        = pop_valid && pop_ready;

   // Accumulate the word and the saturating byte count
   always_comb begin
      word_sum   = oc_add(sum_ff, pop_data.word);
      count_wide = {1'b0, count_ff} + (pop_data.single ? 17'd1 : 17'd2);
      word_count = count_wide[16] ? 16'hFFFF : count_wide[15:0];
      sum_in     = sum_ff;
      count_in   = count_ff;
      if (take) begin
         if (pop_data.last) begin
            sum_in   = '0;
            count_in = '0;
         end else begin
            sum_in   = word_sum;
            count_in = word_count;
         end
      end
      fin_valid_in = (take && pop_data.last) || (fin_valid_ff && !fin_advance);
   end

   // Fold in the pseudo-header when enabled and complement
   always_comb begin
      fin_wide  = {2'd0, fin_sum_ff} + {2'd0, fin_count_ff} + {2'd0, cfg_sum_ff};
      fin_fold  = {1'b0, fin_wide[15:0]} + {15'd0, fin_wide[17:16]};
      fin_fold2 = {1'b0, fin_fold[15:0]} + {16'd0, fin_fold[16]};
      final_sum = cfg.pseudo_mode ? fin_fold2[15:0] : fin_sum_ff;
      rsp_valid_in = rsp_valid_ff;
      if (fin_advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff       <= '0;
         count_ff     <= '0;
         fin_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         sum_ff       <= sum_in;
         count_ff     <= count_in;
         fin_valid_ff <= fin_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Hold payload registers
   always_ff @(posedge clock) begin
      cfg_sum_ff <= cfg_sum_in;
      if (take && pop_data.last) begin
         fin_sum_ff   <= word_sum;
         fin_count_ff <= word_count;
      end
      if (fin_advance) begin
         rsp_checksum_ff <= ~final_sum;
      end
   end

endmodule

[design/internet_checksum_pseudo_header.sv]
// Internet checksum with optional TCP/UDP IPv4 pseudo-header.
// Request channel (req_): one network-order 16-bit word per transaction,
// req_single_byte marks a lone trailing byte in the upper half, and
// req_last_item closes the segment. Response channel (rsp_): one
// transaction carrying the complemented sum for each closing word.
// Config channel (csr_): index 0 pseudo mode, 1 source address,
// 2 destination address, 3 protocol number; write only while idle.
// Words are taken at one word per clock while the queue has room; the
// end-around-carry accumulator adds each word as it pops. The closing
// word passes the queue, the final-sum register and the pseudo-header
// fold into the response register. A FIFO_DEPTH-entry queue sits between
// the word intake and the accumulator, so words keep flowing while a
// response waits; when the receiver stalls, the queue fills and req_ready drops.
// Reset clears the running sum, the byte count and all valid flags, and
// returns the registers to mode 0, zero addresses and protocol 6.
module internet_checksum_pseudo_header #(
   parameter int FIFO_DEPTH = 4
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [15:0]                       req_data_word,
   input  logic                              req_single_byte,
   input  logic                              req_last_item,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [15:0]                       rsp_checksum,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [icph_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [31:0]                       csr_data
);

   icph_pkg::cfg_type   cfg_ff, cfg_in;
   icph_pkg::entry_type push_data;
   icph_pkg::entry_type pop_data;
   logic                push_valid;
   logic                push_ready;
   logic                pop_valid;
   logic                pop_ready;

   assign csr_ready = 1'b1;

   // Decode register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            icph_pkg::CSR_PSEUDO_MODE:         cfg_in.pseudo_mode = csr_data[0];
            icph_pkg::CSR_SOURCE_ADDRESS:      cfg_in.source_address = csr_data;
            icph_pkg::CSR_DESTINATION_ADDRESS: cfg_in.destination_address = csr_data;
            icph_pkg::CSR_PROTOCOL_NUMBER:     cfg_in.protocol_number = csr_data[7:0];
            default:                           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pseudo_mode         <= 1'b0;
         cfg_ff.source_address      <= '0;
         cfg_ff.destination_address <= '0;
         cfg_ff.protocol_number     <= icph_pkg::PROTOCOL_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   icph_front u_front (
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_data_word   (req_data_word),
      .req_single_byte (req_single_byte),
      .req_last_item   (req_last_item),
      .push_valid      (push_valid),
      .push_ready      (push_ready),
      .push_data       (push_data)
   );

   icph_fifo #(
      .DEPTH (FIFO_DEPTH)
   ) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   icph_back u_back (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg_ff),
      .pop_valid    (pop_valid),
      .pop_ready    (pop_ready),
      .pop_data     (pop_data),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_checksum (rsp_checksum)
   );

endmodule
